[src/rfbe_pkg.sv]
// Shared widths, opcodes, register indexes and pipeline control type for the fill/blit engine.
package rfbe_pkg;

  // Default largest screen dimension
  localparam int MAX_DIM_DEF = 4096;

  // Field widths
  localparam int SCR_W    = 13;
  localparam int PITCH_W  = 14;
  localparam int COORD_W  = 16;
  localparam int DST_W    = 28;
  localparam int SRC_W    = 32;
  localparam int COLOR_W  = 32;
  localparam int OP_W     = 2;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 96;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 2'd2;

  // Command opcodes
  localparam logic [OP_W-1:0] OP_FILL = 2'd0;
  localparam logic [OP_W-1:0] OP_BLIT = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP = 2'd2;

  // Control handed from the input register to the walker
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            advance;
  } pipe_ctl_t;

endpackage

[src/rfbe_clip_axis.sv]
// Clips one axis of a signed rectangle against a saturated screen limit.
module rfbe_clip_axis
  import rfbe_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int DW      = $clog2(MAX_DIM + 1)
) (
  input  logic [COORD_W-1:0] pos,
  input  logic [COORD_W-1:0] len,
  input  logic [SCR_W-1:0]   limit,
  output logic [DW-1:0]      clip_start,
  output logic [DW-1:0]      clip_len,
  output logic [COORD_W-1:0] skip,
  output logic               nonempty
);

  localparam int CW = (DW > SCR_W) ? DW : SCR_W;

  logic [CW-1:0]     lim_ext;
  logic [CW-1:0]     lim_sat;
  logic signed [17:0] lim_s;
  logic signed [17:0] pos_s;
  logic signed [17:0] len_s;
  logic signed [17:0] len_a;
  logic signed [17:0] start_s;
  logic signed [17:0] end_s;
  logic signed [17:0] len_b;
  logic               neg;

  // Saturate the screen size to the largest supported dimension
  assign lim_ext = CW'(limit);
  assign lim_sat = (lim_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : lim_ext;
  assign lim_s   = $signed(18'(lim_sat));

  // Cut off the part left of / above zero
  assign neg     = pos[COORD_W-1];
  assign pos_s   = $signed({{2{pos[COORD_W-1]}}, pos});
  assign len_s   = $signed({2'b00, len});
  assign len_a   = neg ? (len_s + pos_s) : len_s;
  assign start_s = neg ? 18'sd0 : pos_s;
  assign skip    = neg ? (~pos + 16'd1) : '0;

  // Cut off the part beyond the screen edge
  assign end_s = start_s + len_a;
  assign len_b = (end_s > lim_s) ? (lim_s - start_s) : len_a;

  assign nonempty   = (len_b > 18'sd0);
  assign clip_len   = DW'(len_b);
  assign clip_start = DW'(start_s);

endmodule

[src/rfbe_walker.sv]
// Command state, raster walk and registered pixel-operation output.
module rfbe_walker
  import rfbe_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int DW      = $clog2(MAX_DIM + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pipe_ctl_t             ctl,
  input  logic [DW-1:0]         x0,
  input  logic [DW-1:0]         y0,
  input  logic [DW-1:0]         cw,
  input  logic [DW-1:0]         ch,
  input  logic [COORD_W-1:0]    sx,
  input  logic [COORD_W-1:0]    sy,
  input  logic                  nonempty,
  input  logic [COLOR_W-1:0]    color,
  input  logic [COORD_W-1:0]    spitch,
  input  logic [PITCH_W-1:0]    row_pitch,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]            out_tuser,
  output logic                  out_tlast
);

  // Command state
  logic               busy_r, busy_nxt;
  logic               copy_r, copy_nxt;
  logic [DW-1:0]      cw_r, cw_nxt;
  logic [DW-1:0]      ch_r, ch_nxt;
  logic [DW-1:0]      col_r, col_nxt;
  logic [DW-1:0]      row_r, row_nxt;
  logic [DST_W-1:0]   dbase_r, dbase_nxt;
  logic [SRC_W-1:0]   sbase_r, sbase_nxt;
  logic [COLOR_W-1:0] hcol_r, hcol_nxt;
  logic [COORD_W-1:0] hsp_r, hsp_nxt;

  // Output register
  logic               ovalid_r, ovalid_nxt;
  logic               ocopy_r, ocopy_nxt;
  logic [DST_W-1:0]   odst_r, odst_nxt;
  logic [SRC_W-1:0]   osrc_r, osrc_nxt;
  logic [COLOR_W-1:0] ocol_r, ocol_nxt;
  logic               olast_r, olast_nxt;

  logic [DW:0]        col_inc;
  logic [DW:0]        row_inc;
  logic               row_end;
  logic               last;
  logic               is_start;
  logic               is_step;
  logic [DW+13:0]     dmul;
  logic [SRC_W-1:0]   smul;
  logic [DST_W-1:0]   dst_start;
  logic [SRC_W-1:0]   src_start;

  // Start-of-command origins
  assign dmul      = y0 * row_pitch;
  assign smul      = sy * spitch;
  assign dst_start = DST_W'(dmul) + DST_W'(x0);
  assign src_start = smul + SRC_W'(sx);

  // Raster position tests
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign row_end = (col_inc >= {1'b0, cw_r});
  assign last    = row_end && (row_inc >= {1'b0, ch_r});

  assign is_start = ctl.valid && ((ctl.op == OP_FILL) || (ctl.op == OP_BLIT));
  assign is_step  = ctl.valid && (ctl.op == OP_STEP) && busy_r;

  // Next state and next output
  always_comb begin
    busy_nxt   = busy_r;
    copy_nxt   = copy_r;
    cw_nxt     = cw_r;
    ch_nxt     = ch_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    dbase_nxt  = dbase_r;
    sbase_nxt  = sbase_r;
    hcol_nxt   = hcol_r;
    hsp_nxt    = hsp_r;
    ovalid_nxt = ovalid_r;
    ocopy_nxt  = ocopy_r;
    odst_nxt   = odst_r;
    osrc_nxt   = osrc_r;
    ocol_nxt   = ocol_r;
    olast_nxt  = olast_r;
    if (ctl.advance) begin
      ovalid_nxt = is_step;
      if (is_start) begin
        busy_nxt = nonempty;
        if (nonempty) begin
          copy_nxt  = (ctl.op == OP_BLIT);
          cw_nxt    = cw;
          ch_nxt    = ch;
          col_nxt   = '0;
          row_nxt   = '0;
          dbase_nxt = dst_start;
          if (ctl.op == OP_BLIT) begin
            hsp_nxt   = spitch;
            hcol_nxt  = '0;
            sbase_nxt = src_start;
          end else begin
            hsp_nxt   = '0;
            hcol_nxt  = color;
            sbase_nxt = '0;
          end
        end
      end else if (is_step) begin
        ocopy_nxt = copy_r;
        odst_nxt  = dbase_r + DST_W'(col_r);
        osrc_nxt  = copy_r ? (sbase_r + SRC_W'(col_r)) : '0;
        ocol_nxt  = copy_r ? '0 : hcol_r;
        olast_nxt = last;
        col_nxt   = col_inc[DW-1:0];
        if (row_end) begin
          col_nxt   = '0;
          row_nxt   = row_inc[DW-1:0];
          dbase_nxt = dbase_r + DST_W'(row_pitch);
          sbase_nxt = sbase_r + SRC_W'(hsp_r);
        end
        if (last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    copy_r  <= copy_nxt;
    cw_r    <= cw_nxt;
    ch_r    <= ch_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    dbase_r <= dbase_nxt;
    sbase_r <= sbase_nxt;
    hcol_r  <= hcol_nxt;
    hsp_r   <= hsp_nxt;
    ocopy_r <= ocopy_nxt;
    odst_r  <= odst_nxt;
    osrc_r  <= osrc_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0000, ocol_r, osrc_r, odst_r};
  assign out_tuser  = ocopy_r;
  assign out_tlast  = olast_r;

  // The walk position stays inside the clipped rectangle
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (col_r < cw_r))
    else $error("column count outside clipped width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (row_r < ch_r))
    else $error("row count outside clipped height");

  // Issuing the final pixel ends the command
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && is_step && last) |=> (!busy_r && out_tvalid && out_tlast))
    else $error("final pixel did not end the command");

  // Busy only drops on a final pixel or a replacing start
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(ctl.advance && (is_start || (is_step && last))))
    else $error("command ended without cause");

endmodule

[src/clipped_rect_fill_blit_engine.sv]
// Top level of the clipped rectangle fill and blit engine.
//
// Usage: write screen_width (index 0), screen_height (1) and row_pitch (2)
// on the cfg_ channel while the engine is idle; cfg_ready is always high.
// Requests arrive on the in_ stream: tuser carries the opcode (start fill,
// start blit, step). A start request clips the rectangle to the screen and
// produces nothing; an empty clipped rectangle leaves the engine idle, and
// any start replaces a command still running. Each step request while a
// command runs produces one pixel operation on the out_ stream, with tuser
// set for copies and tlast on the final pixel of the command.
// Order: a request is registered after clipping, then walked into the
// output register, so a pixel operation is offered from the output
// register once its step has left the input register.
// Throughput: one request per cycle while the receiver does not stall;
// the walker updates its counters and row bases on each step, and two
// multiplies per start (destination and source origins) sit in the
// walker stage. Reset (rst_n, synchronous) clears the configuration
// registers, ends any command and empties both pipeline stages. When
// the receiver stalls, the result holds in the output register and the
// input stage stops taking requests once it is full.
module clipped_rect_fill_blit_engine
  import rfbe_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Command requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rect_x, rect_y, rect_w, rect_h, color, source_pitch
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OP_W-1:0]       in_tuser,
  // Pixel operations
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // dst_index, src_index, fill_color, 4 pad bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  // is_copy
  output logic [0:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [SCR_W-1:0]   scr_w_r;
  logic [SCR_W-1:0]   scr_h_r;
  logic [PITCH_W-1:0] pitch_r;

  logic [DW-1:0]      cx_start, cy_start, cx_len, cy_len;
  logic [COORD_W-1:0] cx_skip, cy_skip;
  logic               cx_ne, cy_ne;

  logic               s1_valid_r;
  logic [OP_W-1:0]    s1_op_r;
  logic [DW-1:0]      s1_x0_r, s1_y0_r, s1_w_r, s1_h_r;
  logic [COORD_W-1:0] s1_sx_r, s1_sy_r;
  logic               s1_ne_r;
  logic [COLOR_W-1:0] s1_color_r;
  logic [COORD_W-1:0] s1_spitch_r;

  logic               advance;
  logic               in_fire;
  pipe_ctl_t          ctl;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= '0;
      scr_h_r <= '0;
      pitch_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data[SCR_W-1:0];
        REG_ROW_PITCH:     pitch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clip both axes ahead of the input register
  rfbe_clip_axis #(.MAX_DIM(MAX_DIM), .DW(DW)) u_clip_x (
    .pos        (in_tdata[15:0]),
    .len        (in_tdata[47:32]),
    .limit      (scr_w_r),
    .clip_start (cx_start),
    .clip_len   (cx_len),
    .skip       (cx_skip),
    .nonempty   (cx_ne)
  );

  rfbe_clip_axis #(.MAX_DIM(MAX_DIM), .DW(DW)) u_clip_y (
    .pos        (in_tdata[31:16]),
    .len        (in_tdata[63:48]),
    .limit      (scr_h_r),
    .clip_start (cy_start),
    .clip_len   (cy_len),
    .skip       (cy_skip),
    .nonempty   (cy_ne)
  );

  // Stage handshake
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_tuser;
      s1_x0_r     <= cx_start;
      s1_y0_r     <= cy_start;
      s1_w_r      <= cx_len;
      s1_h_r      <= cy_len;
      s1_sx_r     <= cx_skip;
      s1_sy_r     <= cy_skip;
      s1_ne_r     <= cx_ne && cy_ne;
      s1_color_r  <= in_tdata[95:64];
      s1_spitch_r <= in_tdata[111:96];
    end
  end

  assign ctl.valid   = s1_valid_r;
  assign ctl.op      = s1_op_r;
  assign ctl.advance = advance;

  rfbe_walker #(.MAX_DIM(MAX_DIM), .DW(DW)) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .x0         (s1_x0_r),
    .y0         (s1_y0_r),
    .cw         (s1_w_r),
    .ch         (s1_h_r),
    .sx         (s1_sx_r),
    .sy         (s1_sy_r),
    .nonempty   (s1_ne_r),
    .color      (s1_color_r),
    .spitch     (s1_spitch_r),
    .row_pitch  (pitch_r),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[test/tb_clipped_rect_fill_blit_engine.sv]
// Self-checking testbench for the clipped rectangle fill and blit engine.
module tb_clipped_rect_fill_blit_engine;
  import rfbe_pkg::*;

  // Opcode and register index the engine must ignore
  localparam logic [OP_W-1:0]      OP_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_PCT  = 26;
  localparam int HOLD_CYC  = 300;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    bit        is_copy;
    bit [27:0] dst;
    bit [31:0] src;
    bit [31:0] color;
    bit        last;
  } pixel_op_t;

  // Tracks the engine's state and the pixel operations still owed by it
  class pixel_op_tracker;
    int unsigned scr_w, scr_h, pitch;
    bit          busy, copy_mode;
    int unsigned clip_w, clip_h, col, row;
    bit [27:0]   dst_base;
    bit [31:0]   src_base, color;
    bit [15:0]   blit_pitch;
    pixel_op_t   owed_pixels[$];
    int unsigned errors, checked, live_requests, fills, blits;

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val[12:0];
        REG_SCREEN_HEIGHT: scr_h = val[12:0];
        REG_ROW_PITCH:     pitch = val;
        default: ;
      endcase
    endfunction

    // One axis: visible length, clipped start and amount cut off the low side
    function int clip_axis(int pos, int len, int unsigned limit, output int start,
                           output int skip);
      int lim;
      lim   = (limit > MAX_DIM_DEF) ? MAX_DIM_DEF : limit;
      skip  = 0;
      start = 0;
      if (len <= 0) return 0;
      if (pos < 0) begin
        skip = -pos;
        len  = len + pos;
        pos  = 0;
      end
      if (pos + len > lim) len = lim - pos;
      start = pos;
      return (len > 0) ? len : 0;
    endfunction

    function void note_request(bit [OP_W-1:0] op, bit [IN_DATA_W-1:0] data);
      int        w, h, x0, y0, sx, sy;
      pixel_op_t px;
      bit        last;
      if (op == OP_FILL || op == OP_BLIT) begin
        live_requests++;
        w = clip_axis($signed(data[15:0]), data[47:32], scr_w, x0, sx);
        h = clip_axis($signed(data[31:16]), data[63:48], scr_h, y0, sy);
        busy = 0;
        if (w <= 0 || h <= 0) return;
        copy_mode = (op == OP_BLIT);
        clip_w    = w;
        clip_h    = h;
        col       = 0;
        row       = 0;
        dst_base  = 28'(32'(y0) * pitch + 32'(x0));
        if (copy_mode) begin
          blits++;
          blit_pitch = data[111:96];
          color      = '0;
          src_base   = 32'(sy) * 32'(blit_pitch) + 32'(sx);
        end else begin
          fills++;
          color      = data[95:64];
          blit_pitch = '0;
          src_base   = '0;
        end
        busy = 1;
        return;
      end
      if (op != OP_STEP || !busy) return;
      // Step: one pixel in raster order
      live_requests++;
      last       = (col + 1 >= clip_w) && (row + 1 >= clip_h);
      px.is_copy = copy_mode;
      px.dst     = dst_base + 28'(col);
      px.src     = copy_mode ? src_base + col : '0;
      px.color   = copy_mode ? '0 : color;
      px.last    = last;
      owed_pixels.push_back(px);
      col++;
      if (col >= clip_w) begin
        col = 0;
        row++;
        dst_base = dst_base + 28'(pitch);
        src_base = src_base + blit_pitch;
      end
      if (last) busy = 0;
    endfunction

    function void check_pixel(bit is_copy, bit [OUT_DATA_W-1:0] data, bit last);
      pixel_op_t px;
      checked++;
      if (owed_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected pixel op: copy=%0b dst=%h src=%h color=%h last=%0b",
                   is_copy, data[27:0], data[59:28], data[91:60], last);
        return;
      end
      px = owed_pixels.pop_front();
      if (px.is_copy != is_copy || px.dst != data[27:0] || px.src != data[59:28] ||
          px.color != data[91:60] || px.last != last || data[95:92] != 4'd0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("pixel op %0d mismatch: expected copy=%0b dst=%h src=%h color=%h last=%0b",
                   checked, px.is_copy, px.dst, px.src, px.color, px.last);
          $display("  got copy=%0b dst=%h src=%h color=%h last=%0b pad=%h",
                   is_copy, data[27:0], data[59:28], data[91:60], last, data[95:92]);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction

    function int unsigned pixels_left();
      if (!busy) return 0;
      return (clip_h - row - 1) * clip_w + (clip_w - col);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  pixel_op_tracker tracker = new();
  bit              steady;
  bit              hold_req;
  int unsigned     hold_offs;
  int unsigned     cfg_writes;
  int unsigned     requests;

  clipped_rect_fill_blit_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #3000000;
    $display("tb_clipped_rect_fill_blit_engine: done, errors");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 0;
        hold_offs++;
      end else begin
        out_tready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_pixel(out_tuser[0], out_tdata, out_tlast);
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(int x, int y, int w, int h,
                                                    logic [31:0] color, logic [15:0] sp);
    return {sp, color, 16'(h), 16'(w), 16'(y), 16'(x)};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_payload();
    return pack_cmd($urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
    @(negedge clk);
    // Idle cycle by cycle so about a quarter of the cycles carry nothing
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(op, data);
    requests++;
  endtask

  task automatic step(int unsigned n);
    repeat (n) send_request(OP_STEP, rand_payload());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let the engine drain: all owed pixels out, then the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_screen(int unsigned w, int unsigned h, int unsigned p);
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_ROW_PITCH, CFG_DATA_W'(p));
  endtask

  function automatic int rand_coord(int unsigned limit);
    int unsigned cap;
    cap = (limit > MAX_DIM_DEF) ? MAX_DIM_DEF : limit;
    if ($urandom_range(99) < 75) return int'($urandom_range(0, cap + 8)) - 8;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(1, 10);
    if (r < 75) return 0;
    if (r < 90) return $urandom_range(11, 64);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return 0;
    if (r < 55) return $urandom_range(1, 24);
    if (r < 70) return MAX_DIM_DEF;
    if (r < 88) return $urandom_range(25, 4095);
    return $urandom_range(4097, 8191);
  endfunction

  // One start with random content, mostly followed by the steps it needs
  task automatic random_command();
    int unsigned r, n;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 4) begin
      send_request(OP_NONE, rand_payload());
      return;
    end
    op = (r < 52) ? OP_FILL : OP_BLIT;
    send_request(op, pack_cmd(rand_coord(tracker.scr_w), rand_coord(tracker.scr_h),
                              rand_len(), rand_len(), $urandom, 16'($urandom)));
    n = tracker.pixels_left();
    if (n > 48) n = $urandom_range(20, 48);
    if (n == 0) begin
      if ($urandom_range(99) < 30) step(1);
      return;
    end
    r = $urandom_range(99);
    if (r < 75)      step(n + $urandom_range(0, 1));
    else if (r < 95) step($urandom_range(1, n));
  endtask

  initial begin
    int unsigned base, sw, sh;
    steady     = 0;
    hold_req   = 0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Small screen: idle step, stray opcode, clipping on every edge
    set_screen(16, 8, 20);
    write_reg(REG_UNUSED, 14'h3FFF);
    step(1);
    send_request(OP_NONE, rand_payload());
    send_request(OP_FILL, pack_cmd(-2, -1, 4, 3, 32'hFFFF_FFFF, 16'h0000));
    step(5);
    send_request(OP_BLIT, pack_cmd(-3, -2, 5, 4, 32'h0000_0000, 16'hFFFF));
    step(4);
    // Zero-size rectangles leave the engine idle
    send_request(OP_FILL, pack_cmd(0, 0, 0, 5, 32'h1234_5678, 16'h0));
    send_request(OP_BLIT, pack_cmd(0, 0, 5, 0, 32'h0, 16'h5));
    step(1);
    // Right/bottom clip, then a new start cuts the fill short
    send_request(OP_FILL, pack_cmd(14, 6, 16'hFFFF, 16'hFFFF, 32'h0, 16'h0));
    step(2);
    send_request(OP_BLIT, pack_cmd(-32768, -32768, 16'hFFFF, 16'hFFFF, 32'h0, 16'h1));
    step(2);
    settle();

    // Row pitch changed while a blit is halfway through
    write_reg(REG_ROW_PITCH, 14'd16383);
    send_request(OP_BLIT, pack_cmd(1, 1, 3, 3, 32'h0, 16'h7));
    step(4);
    settle();
    write_reg(REG_ROW_PITCH, 14'd5);
    step(5);
    settle();

    // Zero screen, then an oversize screen saturated to the largest size
    set_screen(0, 0, 0);
    send_request(OP_FILL, pack_cmd(0, 0, 5, 5, 32'hA5A5_5A5A, 16'h0));
    step(1);
    settle();
    set_screen(8191, 8191, 16383);
    send_request(OP_FILL, pack_cmd(4093, 4094, 8, 8, 32'hDEAD_BEEF, 16'h0));
    step(6);
    settle();

    // Random phases, each on its own screen setting
    base = tracker.live_requests;
    for (int ph = 0; ph < 8; ph++) begin
      sw = rand_dim();
      sh = rand_dim();
      if (ph == 3 || ph == 5) begin
        sw = 64;
        sh = 64;
      end
      set_screen(sw, sh, ($urandom_range(99) < 20) ? sw : $urandom_range(0, 16383));
      steady = (ph == 3);
      if (ph == 5) hold_req = 1;
      while (tracker.live_requests < base + (ph + 1) * 200) random_command();
      settle();
    end
    steady = 0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests (%0d fills, %0d blits started), %0d pixel ops checked",
             requests, tracker.fills, tracker.blits, tracker.checked);
    $display("%0d register writes, %0d long receiver hold-offs", cfg_writes, hold_offs);
    if (tracker.errors == 0) begin
      $display("tb_clipped_rect_fill_blit_engine: done, clean");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("tb_clipped_rect_fill_blit_engine: done, errors");
    end
    $finish;
  end

endmodule
